FILE: sv/pid_ci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_ci_pkg
// Shared widths, register indexes, reset values and stage types of the
// clamped-integral PID unit.
// ----------------------------------------------------------------------------
package pid_ci_pkg;

   localparam int GAIN_W     = 24;
   localparam int ERR_W      = 32;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int ACC_W      = 48;
   localparam int OUT_W      = 48;
   localparam int FRAC_W     = 16;
   localparam int P_W        = GAIN_W + ERR_W - FRAC_W;
   localparam int D_W        = GAIN_W + DIFF_W - FRAC_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_UPPER = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LOWER = CSR_IDX_W'(4);

   // Gains are Q8.16, clamps are Q32.16.
   localparam logic signed [GAIN_W-1:0] GAIN_P_RESET      = 24'sd52429;
   localparam logic signed [GAIN_W-1:0] GAIN_I_RESET      = 24'sd13107;
   localparam logic signed [GAIN_W-1:0] GAIN_D_RESET      = 24'sd0;
   localparam logic signed [ACC_W-1:0]  INTEG_UPPER_RESET = 48'sh0000_FFFF_0000;
   localparam logic signed [ACC_W-1:0]  INTEG_LOWER_RESET = 48'shFFFF_0001_0000;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic signed [ACC_W-1:0]  upper;
      logic signed [ACC_W-1:0]  lower;
   } cfg_type;

   typedef struct packed {
      logic                  cmd;
      logic                  i_en;
      logic signed [P_W-1:0] p;
      logic signed [P_W-1:0] inc;
      logic signed [D_W-1:0] d;
   } term_type;

   typedef struct packed {
      logic                    cmd;
      logic signed [P_W-1:0]   p;
      logic signed [D_W-1:0]   d;
      logic signed [ACC_W-1:0] integ;
   } acc_type;

endpackage

FILE: sv/pid_ci_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_ci_csr
// Gain and clamp registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module pid_ci_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pid_ci_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pid_ci_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pid_ci_pkg::cfg_type                  cfg
);

   pid_ci_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p <= pid_ci_pkg::GAIN_P_RESET;
         cfg_ff.gain_i <= pid_ci_pkg::GAIN_I_RESET;
         cfg_ff.gain_d <= pid_ci_pkg::GAIN_D_RESET;
         cfg_ff.upper  <= pid_ci_pkg::INTEG_UPPER_RESET;
         cfg_ff.lower  <= pid_ci_pkg::INTEG_LOWER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pid_ci_pkg::CSR_GAIN_P:
               cfg_ff.gain_p <= csr_wdata[pid_ci_pkg::GAIN_W-1:0];
            pid_ci_pkg::CSR_GAIN_I:
               cfg_ff.gain_i <= csr_wdata[pid_ci_pkg::GAIN_W-1:0];
            pid_ci_pkg::CSR_GAIN_D:
               cfg_ff.gain_d <= csr_wdata[pid_ci_pkg::GAIN_W-1:0];
            pid_ci_pkg::CSR_INTEG_UPPER:
               cfg_ff.upper <= csr_wdata[pid_ci_pkg::ACC_W-1:0];
            pid_ci_pkg::CSR_INTEG_LOWER:
               cfg_ff.lower <= csr_wdata[pid_ci_pkg::ACC_W-1:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/pid_ci_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_ci_terms
// Input register, error history and the three gain multiplies. Produces the
// proportional term, the integral increment and the derivative term.
// ----------------------------------------------------------------------------
module pid_ci_terms (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pid_ci_pkg::cfg_type                  cfg,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [pid_ci_pkg::ERR_W-1:0]  req_error_in,
   output logic                                 term_valid,
   input  logic                                 term_ready,
   output pid_ci_pkg::term_type                 term
);

   localparam int PROD_W  = pid_ci_pkg::GAIN_W + pid_ci_pkg::ERR_W;
   localparam int PRODD_W = pid_ci_pkg::GAIN_W + pid_ci_pkg::DIFF_W;

   logic                                  s1_valid_ff;
   logic                                  s1_cmd_ff;
   logic                                  s1_den_ff;
   logic signed [pid_ci_pkg::ERR_W-1:0]   s1_err_ff;
   logic signed [pid_ci_pkg::DIFF_W-1:0]  s1_diff_ff;
   logic signed [pid_ci_pkg::ERR_W-1:0]   last_error_ff;
   logic                                  primed_ff;
   logic                                  s2_valid_ff;
   pid_ci_pkg::term_type                  term_ff;
   pid_ci_pkg::term_type                  term_in;

   logic                                  accept;
   logic                                  s2_ready;
   logic                                  s2_load;
   logic signed [pid_ci_pkg::DIFF_W-1:0]  diff_in;
   logic signed [PROD_W-1:0]              prod_p;
   logic signed [PROD_W-1:0]              prod_i;
   logic signed [PRODD_W-1:0]             prod_d;

   assign s2_ready  = !s2_valid_ff || term_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign accept    = req_valid && req_ready;
   assign s2_load   = s1_valid_ff && s2_ready;

   assign diff_in = pid_ci_pkg::DIFF_W'(req_error_in) - pid_ci_pkg::DIFF_W'(last_error_ff);

   // Dropping the low fraction bits of the product is a floor shift.
   assign prod_p = cfg.gain_p * s1_err_ff;
   assign prod_i = cfg.gain_i * s1_err_ff;
   assign prod_d = cfg.gain_d * s1_diff_ff;

   always_comb begin
      term_in.cmd  = s1_cmd_ff;
      term_in.i_en = (cfg.gain_i != '0);
      term_in.p    = prod_p[PROD_W-1:pid_ci_pkg::FRAC_W];
      term_in.inc  = prod_i[PROD_W-1:pid_ci_pkg::FRAC_W];
      term_in.d    = s1_den_ff ? prod_d[PRODD_W-1:pid_ci_pkg::FRAC_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         last_error_ff <= '0;
         primed_ff     <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (accept) begin
            if (req_cmd) begin
               last_error_ff <= '0;
               primed_ff     <= 1'b0;
            end else begin
               last_error_ff <= req_error_in;
               primed_ff     <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_err_ff  <= req_error_in;
         s1_diff_ff <= diff_in;
         s1_den_ff  <= primed_ff;
      end
      if (s2_load) begin
         term_ff <= term_in;
      end
   end

   assign term_valid = s2_valid_ff;
   assign term       = term_ff;

`ifndef SYNTHESIS
   a_clear_history: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd) |=> (!primed_ff && last_error_ff == '0))
      else $error("error history not cleared by a clear word");
   a_first_no_deriv: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_cmd && !primed_ff) |=> (s1_valid_ff && !s1_den_ff))
      else $error("derivative enabled on first sample after clear");
`endif

endmodule

FILE: sv/pid_ci_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_ci_accum
// Integral accumulator: adds the increment, applies the upper and then the
// lower clamp, and hands the terms on for the final sum.
// ----------------------------------------------------------------------------
module pid_ci_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  pid_ci_pkg::cfg_type   cfg,
   input  logic                  term_valid,
   output logic                  term_ready,
   input  pid_ci_pkg::term_type  term,
   output logic                  acc_valid,
   input  logic                  acc_ready,
   output pid_ci_pkg::acc_type   acc
);

   localparam int SUM_W = pid_ci_pkg::ACC_W + 1;

   logic                                 s3_valid_ff;
   logic                                 s3_cmd_ff;
   logic signed [pid_ci_pkg::P_W-1:0]    s3_p_ff;
   logic signed [pid_ci_pkg::D_W-1:0]    s3_d_ff;
   logic signed [pid_ci_pkg::ACC_W-1:0]  integral_acc_ff;
   logic signed [pid_ci_pkg::ACC_W-1:0]  integral_acc_in;

   logic                                 load;
   logic signed [SUM_W-1:0]              integ_sum;
   logic signed [SUM_W-1:0]              upper_x;
   logic signed [SUM_W-1:0]              lower_x;
   logic signed [SUM_W-1:0]              clamp_hi;
   logic signed [SUM_W-1:0]              clamp_lo;

   assign term_ready = !s3_valid_ff || acc_ready;
   assign load       = term_valid && term_ready;

   assign integ_sum = SUM_W'(integral_acc_ff) + SUM_W'(term.inc);
   assign upper_x   = SUM_W'(cfg.upper);
   assign lower_x   = SUM_W'(cfg.lower);

   // The lower clamp wins when the bounds are inverted.
   assign clamp_hi = (integ_sum > upper_x) ? upper_x : integ_sum;
   assign clamp_lo = (clamp_hi < lower_x) ? lower_x : clamp_hi;

   always_comb begin
      if (term.cmd) begin
         integral_acc_in = '0;
      end else if (term.i_en) begin
         integral_acc_in = clamp_lo[pid_ci_pkg::ACC_W-1:0];
      end else begin
         integral_acc_in = integral_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff     <= 1'b0;
         integral_acc_ff <= '0;
      end else begin
         if (term_ready) begin
            s3_valid_ff <= term_valid;
         end
         if (load) begin
            integral_acc_ff <= integral_acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s3_cmd_ff <= term.cmd;
         s3_p_ff   <= term.p;
         s3_d_ff   <= term.d;
      end
   end

   // The accumulator holds while the word sits here, so it is read directly.
   assign acc_valid = s3_valid_ff;
   assign acc.cmd   = s3_cmd_ff;
   assign acc.p     = s3_p_ff;
   assign acc.d     = s3_d_ff;
   assign acc.integ = integral_acc_ff;

`ifndef SYNTHESIS
   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(integral_acc_ff))
      else $error("integral changed without a word");
   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      (load && !term.cmd && term.i_en && cfg.lower <= cfg.upper)
      |=> (integral_acc_ff <= $past(cfg.upper) && integral_acc_ff >= $past(cfg.lower)))
      else $error("integral outside its clamp range");
`endif

endmodule

FILE: sv/pid_ci_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_ci_out
// Sums the three terms, saturates to the output width (a clear word gives zero)
// and holds the result word in the output register.
// ----------------------------------------------------------------------------
module pid_ci_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 acc_valid,
   output logic                                 acc_ready,
   input  pid_ci_pkg::acc_type                  acc,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pid_ci_pkg::OUT_W-1:0]  rsp_drive_out
);

   localparam int SUM_W = pid_ci_pkg::ACC_W + 2;

   logic                                 rsp_valid_ff;
   logic signed [pid_ci_pkg::OUT_W-1:0]  drive_ff;
   logic signed [pid_ci_pkg::OUT_W-1:0]  drive_in;
   logic signed [SUM_W-1:0]              total;
   logic                                 load;

   assign acc_ready = !rsp_valid_ff || rsp_ready;
   assign load      = acc_valid && acc_ready;

   assign total = SUM_W'(acc.p) + SUM_W'(acc.integ) + SUM_W'(acc.d);

   always_comb begin
      if (acc.cmd) begin
         drive_in = '0;
      end else if (total > SUM_W'(pid_ci_pkg::OUT_MAX)) begin
         drive_in = pid_ci_pkg::OUT_MAX;
      end else if (total < SUM_W'(pid_ci_pkg::OUT_MIN)) begin
         drive_in = pid_ci_pkg::OUT_MIN;
      end else begin
         drive_in = total[pid_ci_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc_ready) begin
         rsp_valid_ff <= acc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = drive_ff;

`ifndef SYNTHESIS
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (load && acc.cmd) |=> (rsp_valid && rsp_drive_out == '0))
      else $error("clear word did not give a zero output");
`endif

endmodule

FILE: sv/pid_clamped_integral_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_clamped_integral_unit
// PID controller step with a clamped integral, one error word per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per sample: req_cmd low processes the
//   Q16.16 error in req_error_in, req_cmd high clears the integral, the error
//   history and the first-sample flag. Each word gives exactly one rsp_ word,
//   rsp_drive_out in Q32.16, saturated to 48 bits; a clear word answers zero.
//   Gains and clamps are written on the csr_ port while no word is in flight.
//   Throughput: one word per cycle while the receiver keeps up, set by the
//   integral add-and-clamp, which closes its loop in a single stage.
//   Pipeline: input/history register, gain multiplies, integral update, then
//   sum, saturation and the output register.
//   Reset loads the default gains and clamps and empties the pipeline.
//   When the receiver stalls, each stage holds its word; req_ready drops only
//   once every stage is occupied, and bubbles keep filling meanwhile.
// ----------------------------------------------------------------------------
module pid_clamped_integral_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pid_ci_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pid_ci_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [pid_ci_pkg::ERR_W-1:0]  req_error_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pid_ci_pkg::OUT_W-1:0]  rsp_drive_out
);

   pid_ci_pkg::cfg_type   cfg;
   pid_ci_pkg::term_type  term;
   pid_ci_pkg::acc_type   acc;
   logic                  term_valid;
   logic                  term_ready;
   logic                  acc_valid;
   logic                  acc_ready;

   pid_ci_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pid_ci_terms u_terms (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_error_in (req_error_in),
      .term_valid   (term_valid),
      .term_ready   (term_ready),
      .term         (term)
   );

   pid_ci_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .term_valid (term_valid),
      .term_ready (term_ready),
      .term       (term),
      .acc_valid  (acc_valid),
      .acc_ready  (acc_ready),
      .acc        (acc)
   );

   pid_ci_out u_out (
      .clock         (clock),
      .reset         (reset),
      .acc_valid     (acc_valid),
      .acc_ready     (acc_ready),
      .acc           (acc),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive_out (rsp_drive_out)
   );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clamped-integral PID unit.
// Error and clear words are sent with random gaps while the receiver stalls at
// random. A local model of the controller predicts every drive word, and the
// results are compared in order. Gains and clamps are changed between phases,
// including pinned, inverted and frozen integral settings.
// ----------------------------------------------------------------------------

typedef enum logic {CMD_SAMPLE = 1'b0, CMD_CLEAR = 1'b1} cmd_type;

class pid_drive_scoreboard;
   logic signed [pid_ci_pkg::GAIN_W-1:0] kp, ki, kd;
   logic signed [pid_ci_pkg::ACC_W-1:0]  integ_hi, integ_lo;
   longint                               integ, prev_err;
   bit                                   primed;
   logic signed [pid_ci_pkg::OUT_W-1:0]  drive_q[$];
   int                                   errors;

   function new();
      kp       = pid_ci_pkg::GAIN_P_RESET;
      ki       = pid_ci_pkg::GAIN_I_RESET;
      kd       = pid_ci_pkg::GAIN_D_RESET;
      integ_hi = pid_ci_pkg::INTEG_UPPER_RESET;
      integ_lo = pid_ci_pkg::INTEG_LOWER_RESET;
      integ    = 0;
      prev_err = 0;
      primed   = 0;
      errors   = 0;
   endfunction

   function void write_reg(logic [pid_ci_pkg::CSR_IDX_W-1:0] idx,
                           logic [pid_ci_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         pid_ci_pkg::CSR_GAIN_P:      kp = data[pid_ci_pkg::GAIN_W-1:0];
         pid_ci_pkg::CSR_GAIN_I:      ki = data[pid_ci_pkg::GAIN_W-1:0];
         pid_ci_pkg::CSR_GAIN_D:      kd = data[pid_ci_pkg::GAIN_W-1:0];
         pid_ci_pkg::CSR_INTEG_UPPER: integ_hi = data[pid_ci_pkg::ACC_W-1:0];
         pid_ci_pkg::CSR_INTEG_LOWER: integ_lo = data[pid_ci_pkg::ACC_W-1:0];
         default: ;
      endcase
   endfunction

   function void take_sample(logic cmd, logic signed [pid_ci_pkg::ERR_W-1:0] err);
      longint e, acc, term_p, term_d, sum;
      if (cmd == CMD_CLEAR) begin
         integ    = 0;
         prev_err = 0;
         primed   = 0;
         drive_q.push_back('0);
         return;
      end
      e = err;
      // Products are exact; the shift floors them to Q32.16.
      term_p = (longint'(kp) * e) >>> pid_ci_pkg::FRAC_W;
      if (ki != 0) begin
         acc = integ + ((longint'(ki) * e) >>> pid_ci_pkg::FRAC_W);
         if (acc > longint'(integ_hi)) acc = integ_hi;
         if (acc < longint'(integ_lo)) acc = integ_lo;
         integ = acc;
      end
      term_d   = primed ? (longint'(kd) * (e - prev_err)) >>> pid_ci_pkg::FRAC_W : 0;
      primed   = 1;
      prev_err = e;
      sum = term_p + integ + term_d;
      if (sum > longint'(pid_ci_pkg::OUT_MAX)) sum = pid_ci_pkg::OUT_MAX;
      if (sum < longint'(pid_ci_pkg::OUT_MIN)) sum = pid_ci_pkg::OUT_MIN;
      drive_q.push_back(sum[pid_ci_pkg::OUT_W-1:0]);
   endfunction

   function void check_drive(logic signed [pid_ci_pkg::OUT_W-1:0] got);
      logic signed [pid_ci_pkg::OUT_W-1:0] want;
      if (drive_q.size() == 0) begin
         $display("%0t: unexpected drive word, expected none, actual %0d", $time, got);
         errors++;
         return;
      end
      want = drive_q.pop_front();
      if (got !== want) begin
         $display("%0t: drive_out mismatch, expected %0d, actual %0d", $time, want, got);
         errors++;
      end
   endfunction

   function int pending();
      return drive_q.size();
   endfunction

   function void report_leftover();
      if (drive_q.size() != 0) begin
         $display("%0t: %0d drive words never arrived", $time, drive_q.size());
         errors += drive_q.size();
      end
   endfunction
endclass

module tb;
   import pid_ci_pkg::*;

   localparam int PIPE_LAT = 3;
   localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
   localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sd65536;
   localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
   localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index    = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata    = '0;
   logic                     req_valid    = 1'b0;
   logic                     req_cmd      = CMD_SAMPLE;
   logic signed [ERR_W-1:0]  req_error_in = '0;
   logic                     rsp_ready    = 1'b0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_drive_out;

   bit req_calm = 0;
   bit rsp_calm = 0;

   pid_drive_scoreboard drive_sb = new();

   always #5 clock = ~clock;

   pid_clamped_integral_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_error_in  (req_error_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive_out (rsp_drive_out)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) drive_sb.take_sample(req_cmd, req_error_in);
         if (rsp_valid && rsp_ready) drive_sb.check_drive(rsp_drive_out);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [GAIN_W-1:0] pick_gain();
      int unsigned r;
      logic signed [GAIN_W-1:0] v;
      r = $urandom_range(0, 99);
      v = GAIN_W'($urandom);
      if (r < 40) return v;
      if (r < 65) return v >>> 6;
      if (r < 75) return '0;
      if (r < 85) return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
      return $urandom_range(0, 1) ? GAIN_ONE : -GAIN_ONE;
   endfunction

   function automatic logic signed [ACC_W-1:0] pick_bound();
      int unsigned r;
      logic signed [ACC_W-1:0] v;
      r = $urandom_range(0, 99);
      v = ACC_W'({$urandom, $urandom});
      if (r < 35) return v;
      if (r < 70) return v >>> 12;
      if (r < 85) return $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
      return v >>> 24;
   endfunction

   function automatic logic signed [ERR_W-1:0] pick_error(logic signed [ERR_W-1:0] last);
      int unsigned r;
      logic signed [ERR_W-1:0] v;
      r = $urandom_range(0, 99);
      v = $urandom;
      if (r < 40) return v;
      if (r < 70) return v >>> 10;
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0:       return ERR_MAX;
            1:       return ERR_MIN;
            2:       return '0;
            default: return '1;
         endcase
      end
      // Small steps keep the derivative term modest.
      return last + (v >>> 20);
   endfunction

   // A register write takes the port for one cycle, then the enable drops.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      drive_sb.write_reg(idx, data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Gain writes carry random bits above the register width.
   task automatic set_config(logic signed [GAIN_W-1:0] gp, logic signed [GAIN_W-1:0] gi,
                             logic signed [GAIN_W-1:0] gd, logic signed [ACC_W-1:0] hi,
                             logic signed [ACC_W-1:0] lo);
      csr_write(CSR_GAIN_P, {GAIN_W'($urandom), gp});
      csr_write(CSR_GAIN_I, {GAIN_W'($urandom), gi});
      csr_write(CSR_GAIN_D, {GAIN_W'($urandom), gd});
      csr_write(CSR_INTEG_UPPER, hi);
      csr_write(CSR_INTEG_LOWER, lo);
   endtask

   task automatic send(cmd_type cmd, logic signed [ERR_W-1:0] err);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_error_in <= err;
      do @(posedge clock); while (req_ready !== 1'b1);
      gap = req_calm ? 0 : gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The monitor logs the last accepted word at that same edge, so the count
   // is read only from the following edge on.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drive_sb.pending() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
   endtask

   initial begin
      int unsigned run_len, stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         run_len = $urandom_range(1, 20);
         repeat (run_len) @(posedge clock);
         stall = rsp_calm ? 0 : gap_len();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic signed [ERR_W-1:0] err;
      logic signed [ACC_W-1:0] hi, lo, swap;
      logic signed [GAIN_W-1:0] gi;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset gains: first sample after reset, error extremes, then a clear and a sample.
      send(CMD_SAMPLE, ERR_MAX);
      send(CMD_SAMPLE, ERR_MIN);
      send(CMD_SAMPLE, '1);
      send(CMD_CLEAR, ERR_MAX);
      send(CMD_SAMPLE, 32'sd1);
      wait_drained();

      // Clamps pinned to the top: the integral jumps to full scale and a
      // positive error saturates the output high.
      set_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, OUT_MAX, OUT_MAX);
      send(CMD_SAMPLE, ERR_MAX);
      send(CMD_SAMPLE, ERR_MIN);
      send(CMD_CLEAR, '0);
      send(CMD_SAMPLE, ERR_MIN);
      wait_drained();

      // Negative extremes pinned at the bottom: a positive error saturates low.
      set_config(GAIN_MIN, GAIN_MIN, GAIN_MIN, OUT_MIN, OUT_MIN);
      send(CMD_SAMPLE, ERR_MAX);
      send(CMD_SAMPLE, ERR_MIN);
      send(CMD_SAMPLE, '0);
      wait_drained();

      // Zero integral gain keeps the integral where it was; indexes past the
      // last register must be ignored.
      set_config(GAIN_ONE, '0, GAIN_ONE, OUT_MAX, OUT_MIN);
      for (int idx = int'(CSR_INTEG_LOWER) + 1; idx < (1 << CSR_IDX_W); idx++)
         csr_write(CSR_IDX_W'(idx), CSR_DATA_W'({$urandom, $urandom}));
      send(CMD_SAMPLE, 32'sd100);
      send(CMD_SAMPLE, -32'sd100);
      send(CMD_SAMPLE, '0);
      wait_drained();

      // Lower clamp above the upper one: the lower clamp wins.
      set_config(GAIN_ONE, GAIN_ONE, GAIN_ONE, -(48'sd1000 <<< FRAC_W), 48'sd1000 <<< FRAC_W);
      send(CMD_SAMPLE, 32'sd5);
      send(CMD_SAMPLE, -32'sd5);
      send(CMD_SAMPLE, '0);
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         req_calm = (ph == 3) || (ph == 7);
         rsp_calm = (ph == 5) || (ph == 7);
         hi = pick_bound();
         lo = pick_bound();
         if (lo > hi && $urandom_range(0, 99) < 85) begin
            swap = hi;
            hi   = lo;
            lo   = swap;
         end
         gi = pick_gain();
         set_config(pick_gain(), gi, pick_gain(), hi, lo);
         err = '0;
         for (int n = 0; n < 110; n++) begin
            if (n == 55 && (ph == 0 || $urandom_range(0, 1) == 1)) wait_drained();
            err = pick_error(err);
            if ($urandom_range(0, 99) < 3) send(CMD_CLEAR, err);
            else send(CMD_SAMPLE, err);
         end
         wait_drained();
      end

      drive_sb.report_leftover();
      if (drive_sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
